// ===== sv/lbr_pkg.sv =====
package lbr_pkg;

	// brightness width
	localparam int LEVEL_W = 8;

	// configuration register indexes
	localparam logic [1:0] REG_PEAK    = 2'd0;
	localparam logic [1:0] REG_FLOOR   = 2'd1;
	localparam logic [1:0] REG_STEPS   = 2'd2;
	localparam logic [1:0] REG_FALLING = 2'd3;

	// request from the sequencer to the arithmetic unit
	typedef struct packed {
		logic start;
		logic round_up;
	} lbr_req_t;

	// response from the arithmetic unit
	typedef struct packed {
		logic                done;
		logic [LEVEL_W-1:0]  quot;
	} lbr_rsp_t;

endpackage

// ===== sv/lbr_muldiv.sv =====
module lbr_muldiv #(
	parameter int STEP_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lbr_pkg::lbr_req_t           req,
	input  logic [STEP_BITS:0]          count,
	input  logic [lbr_pkg::LEVEL_W-1:0] diff,
	input  logic [STEP_BITS-1:0]        steps,
	output lbr_pkg::lbr_rsp_t           rsp
);

	localparam int LW = lbr_pkg::LEVEL_W;
	localparam int PW = STEP_BITS + 1 + LW;
	localparam int IW = $clog2(PW);

	localparam logic [2:0] U_IDLE = 3'd0;
	localparam logic [2:0] U_MUL  = 3'd1;
	localparam logic [2:0] U_ADD  = 3'd2;
	localparam logic [2:0] U_DEC  = 3'd3;
	localparam logic [2:0] U_DIV  = 3'd4;
	localparam logic [2:0] U_DONE = 3'd5;

	logic [2:0]           st_q;
	logic [IW-1:0]        iter_q;
	logic                 round_q;
	logic [PW-1:0]        acc_q;
	logic [STEP_BITS-1:0] rem_q;
	logic [LW-1:0]        diff_q;
	logic [STEP_BITS:0]   cnt_q;
	logic [STEP_BITS-1:0] steps_q;

	logic [PW-1:0]        op_a;
	logic [PW-1:0]        op_b;
	logic                 op_sub;
	logic [PW:0]          sum;
	logic                 carry;
	logic [STEP_BITS:0]   rem_shift;

	// operand select for the shared adder
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (st_q)
			U_MUL: begin
				op_a = {acc_q[PW-2:0], 1'b0};
				op_b = diff_q[LW-1] ? PW'(cnt_q) : '0;
			end
			U_ADD: begin
				op_a = acc_q;
				op_b = PW'(steps_q);
			end
			U_DEC: begin
				op_a   = acc_q;
				op_b   = PW'(1);
				op_sub = 1'b1;
			end
			U_DIV: begin
				op_a   = PW'(rem_shift);
				op_b   = PW'(steps_q);
				op_sub = 1'b1;
			end
			default: begin
				op_a   = '0;
			end
		endcase
	end

	// shared adder / subtractor, carry out means no borrow
	assign rem_shift = {rem_q, acc_q[PW-1]};
	assign sum       = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (PW+1)'(op_sub);
	assign carry     = sum[PW];

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			iter_q <= '0;
		end else begin
			case (st_q)
				U_IDLE: begin
					if (req.start) begin
						st_q   <= U_MUL;
						iter_q <= IW'(LW - 1);
					end
				end
				U_MUL: begin
					if (iter_q == '0) begin
						st_q   <= round_q ? U_ADD : U_DIV;
						iter_q <= IW'(PW - 1);
					end else begin
						iter_q <= iter_q - 1'b1;
					end
				end
				U_ADD: begin
					st_q <= U_DEC;
				end
				U_DEC: begin
					st_q <= U_DIV;
				end
				U_DIV: begin
					if (iter_q == '0) begin
						st_q <= U_DONE;
					end else begin
						iter_q <= iter_q - 1'b1;
					end
				end
				U_DONE: begin
					st_q <= U_IDLE;
				end
				default: begin
					st_q <= U_IDLE;
				end
			endcase
		end
	end

	// datapath registers: shift-add multiply, rounding add and decrement on the falling side, then restoring divide
	always_ff @(posedge clk) begin
		case (st_q)
			U_IDLE: begin
				if (req.start) begin
					acc_q   <= '0;
					rem_q   <= '0;
					diff_q  <= diff;
					cnt_q   <= count;
					steps_q <= steps;
					round_q <= req.round_up;
				end
			end
			U_MUL: begin
				acc_q  <= sum[PW-1:0];
				diff_q <= {diff_q[LW-2:0], 1'b0};
			end
			U_ADD, U_DEC: begin
				acc_q <= sum[PW-1:0];
			end
			U_DIV: begin
				rem_q <= carry ? sum[STEP_BITS-1:0] : rem_shift[STEP_BITS-1:0];
				acc_q <= {acc_q[PW-2:0], carry};
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign rsp.done = (st_q == U_DONE);
	assign rsp.quot = acc_q[LW-1:0];

endmodule

// ===== sv/led_breathe_ramp.sv =====
// channel   direction  handshake              payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// in        in         in_valid / in_ready    restart
// out       out        out_valid / out_ready  level, falling, turned
//
// each transaction runs through the serial unit from accept to result: 8 multiply steps,
// 2 rounding steps on the falling side, STEP_BITS + 9 divide steps and a handoff state;
// in_ready is low meanwhile, so the next transaction is not taken before the result is done.
// reset clears the configuration, the step count and the direction.
// a result waiting on out_ready holds the block; the next transaction is taken once
// the result register is loaded.
module led_breathe_ramp #(
	parameter int STEP_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [1:0]                             cfg_index,
	input  logic [((STEP_BITS > 8) ? STEP_BITS : 8)-1:0] cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   restart,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [lbr_pkg::LEVEL_W-1:0]            level,
	output logic                                   falling,
	output logic                                   turned
);

	localparam int LW = lbr_pkg::LEVEL_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;

	logic [1:0]           state_q;
	logic [LW-1:0]        peak_q;
	logic [LW-1:0]        floor_q;
	logic [STEP_BITS-1:0] steps_q;
	logic                 start_fall_q;
	logic [STEP_BITS:0]   count_q;
	logic                 down_q;
	logic                 op_dir_q;
	logic                 op_turn_q;
	logic                 out_valid_q;
	logic [LW-1:0]        level_q;
	logic                 falling_q;
	logic                 turned_q;

	logic                 accept;
	logic [STEP_BITS:0]   count_eff;
	logic                 dir_eff;
	logic [STEP_BITS:0]   count_inc;
	logic                 turn;
	logic [LW-1:0]        diff;
	logic [LW-1:0]        quot;
	logic [LW-1:0]        level_new;
	logic                 out_free;
	logic                 load_out;
	lbr_pkg::lbr_req_t    req;
	lbr_pkg::lbr_rsp_t    rsp;

	// tick decode: restart reloads before the level is formed
	assign accept    = in_valid && in_ready;
	assign count_eff = restart ? '0 : count_q;
	assign dir_eff   = restart ? start_fall_q : down_q;
	assign count_inc = count_eff + 1'b1;
	assign turn      = (count_inc > {1'b0, steps_q});
	assign diff      = peak_q - floor_q;

	assign req.start    = accept;
	assign req.round_up = dir_eff;

	lbr_muldiv #(
		.STEP_BITS (STEP_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.count  (count_eff),
		.diff   (diff),
		.steps  (steps_q),
		.rsp    (rsp)
	);

	// level from the quotient, zero steps means a zero step
	assign quot      = (steps_q == '0) ? '0 : rsp.quot;
	assign level_new = op_dir_q ? (peak_q - quot) : (floor_q + quot);
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = out_free && ((state_q == S_RUN && rsp.done) || state_q == S_HOLD);

	assign in_ready = (state_q == S_IDLE);

	// sequencer and ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			peak_q       <= '0;
			floor_q      <= '0;
			steps_q      <= '0;
			start_fall_q <= 1'b0;
			count_q      <= '0;
			down_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (rsp.done) begin
						state_q <= out_free ? S_IDLE : S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// configuration write reloads the ramp, otherwise advance the ramp at accept
			if (cfg_we) begin
				count_q <= '0;
				down_q  <= (cfg_index == lbr_pkg::REG_FALLING) ? cfg_data[0] : start_fall_q;
				case (cfg_index)
					lbr_pkg::REG_PEAK:    peak_q       <= cfg_data[LW-1:0];
					lbr_pkg::REG_FLOOR:   floor_q      <= cfg_data[LW-1:0];
					lbr_pkg::REG_STEPS:   steps_q      <= cfg_data[STEP_BITS-1:0];
					lbr_pkg::REG_FALLING: start_fall_q <= cfg_data[0];
					default: begin
						peak_q <= peak_q;
					end
				endcase
			end else if (accept) begin
				count_q <= turn ? '0 : count_inc;
				down_q  <= turn ? !dir_eff : dir_eff;
			end

			// result register valid
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// transaction operands and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_dir_q  <= dir_eff;
			op_turn_q <= turn;
		end
		if (load_out) begin
			level_q   <= level_new;
			falling_q <= op_dir_q;
			turned_q  <= op_turn_q;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign falling   = falling_q;
	assign turned    = turned_q;

	// an accepted transaction makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("block still ready after accepting a transaction");

	// the unit only finishes while a transaction is running
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == S_RUN))
		else $error("arithmetic unit done outside of run");

	// the step count never passes the configured steps
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= {1'b0, steps_q})
		else $error("step count beyond ramp steps");

	// a result is loaded only into a free result register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid || out_ready))
		else $error("result register overwritten");

endmodule
